FILE: sv/rlsarx_pkg.sv
package rlsarx_pkg;

  localparam int unsigned MODEL_ORDER_DEF = 2;
  localparam int unsigned IC_W = 23;
  localparam int unsigned SMP_W = 16;
  localparam int unsigned Q_W = 48;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned IDX_W = 4;
  localparam logic [IC_W-1:0] IC_RESET = 23'd1000000;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_ONE = q_t'(48'sd1 <<< FRAC_W);
  localparam q_t Q_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam q_t Q_MIN = 48'sh8000_0000_0000;

  // Saturating add of two Q values
  function automatic q_t sadd(input q_t a, input q_t b);
    logic signed [Q_W:0] sum;
    sum = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (sum[Q_W] != sum[Q_W-1]) begin
      sadd = sum[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      sadd = sum[Q_W-1:0];
    end
  endfunction

  // Saturating subtract of two Q values
  function automatic q_t ssub(input q_t a, input q_t b);
    logic signed [Q_W:0] dif;
    dif = {a[Q_W-1], a} - {b[Q_W-1], b};
    if (dif[Q_W] != dif[Q_W-1]) begin
      ssub = dif[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      ssub = dif[Q_W-1:0];
    end
  endfunction

  // Sample to Q format
  function automatic q_t smp2q(input logic signed [SMP_W-1:0] x);
    smp2q = {{(Q_W-SMP_W-FRAC_W){x[SMP_W-1]}}, x, {FRAC_W{1'b0}}};
  endfunction

endpackage

FILE: sv/rlsarx_mul.sv
module rlsarx_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  rlsarx_pkg::q_t           a,
  input  rlsarx_pkg::q_t           b,
  output logic                     done,
  output rlsarx_pkg::q_t           res
);

  localparam int unsigned HW = rlsarx_pkg::FRAC_W;
  localparam int unsigned AW = 50;

  logic [rlsarx_pkg::Q_W-1:0] ua_r, ub_r;
  logic            neg_r, sat_r, busy_r, done_r;
  logic [2:0]      step_r;
  logic [2*HW-1:0] p_r;
  logic [AW-1:0]   acc_r;
  rlsarx_pkg::q_t  res_r;
  logic [HW-1:0]   opx, opy;
  logic [AW-1:0]   term;
  logic [AW-1:0]   lim;
  logic [AW-1:0]   mag;

  // Pick the partial product for this step
  always_comb begin
    unique case (step_r)
      3'd0:    begin opx = ua_r[2*HW-1:HW]; opy = ub_r[2*HW-1:HW]; end
      3'd1:    begin opx = ua_r[2*HW-1:HW]; opy = ub_r[HW-1:0];    end
      3'd2:    begin opx = ua_r[HW-1:0];    opy = ub_r[2*HW-1:HW]; end
      default: begin opx = ua_r[HW-1:0];    opy = ub_r[HW-1:0];    end
    endcase
  end

  // Align the previous partial product
  always_comb begin
    unique case (step_r)
      3'd1:    term = AW'({p_r[HW-2:0], {HW{1'b0}}});
      3'd2:    term = AW'(p_r);
      3'd3:    term = AW'(p_r);
      default: term = AW'(p_r >> HW);
    endcase
    lim = neg_r ? (AW'(1) << 47) : ((AW'(1) << 47) - AW'(1));
    mag = (sat_r || acc_r > lim) ? lim : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 3'd1;
      end
    end
  end

  // Take magnitudes, then run four 24x24 products and sum them
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[rlsarx_pkg::Q_W-1] != b[rlsarx_pkg::Q_W-1];
      ua_r  <= a[rlsarx_pkg::Q_W-1] ? -a : a;
      ub_r  <= b[rlsarx_pkg::Q_W-1] ? -b : b;
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      if (step_r < 3'd4) begin
        p_r <= opx * opy;
      end
      if (step_r >= 3'd1 && step_r <= 3'd4) begin
        acc_r <= acc_r + term;
      end
      if (step_r == 3'd1 && p_r >= (2*HW)'(1 << (HW-1))) begin
        sat_r <= 1'b1;
      end
      if (step_r == 3'd5) begin
        res_r <= neg_r ? -rlsarx_pkg::q_t'(mag[rlsarx_pkg::Q_W-1:0])
                       : rlsarx_pkg::q_t'(mag[rlsarx_pkg::Q_W-1:0]);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: sv/rlsarx_div.sv
module rlsarx_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  rlsarx_pkg::q_t den,
  output logic           done,
  output rlsarx_pkg::q_t quo
);

  localparam int unsigned W = rlsarx_pkg::Q_W;

  logic [W-1:0] den_r;
  logic [W:0]   rem_r;
  logic [W:0]   q_r;
  logic [5:0]   cnt_r;
  logic         busy_r, done_r;
  logic [W:0]   rem_sh;
  logic         fit;

  // One quotient bit per cycle of 2^48 / den
  always_comb begin
    rem_sh = {rem_r[W-1:0], cnt_r == 6'd0};
    fit    = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(W)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fit ? rem_sh - {1'b0, den_r} : rem_sh;
      q_r   <= {q_r[W-1:0], fit};
    end
  end

  assign done = done_r;
  assign quo  = q_r[W-1:0];

endmodule

FILE: sv/rls_arx_identifier.sv
// Channel | Dir | Fields (low bit up)
// in_     | in  | tdata: plant_input[15:0], plant_output[31:16]
// out_    | out | tdata: coefficient_index[3:0], coefficient_value[51:4]; tlast
// cfg_    | in  | wr_data: initial_covariance
// An item (N = 2*MODEL_ORDER) runs 5*N*N + 3*N products on the one 24x24 multiplier
// and one division between its accept and its N results.
// Reset and each configuration write start a covariance load of all N*N entries.
// in_tready is high only between items; results wait in place while out_tready is low.
module rls_arx_identifier #(
  parameter int unsigned MODEL_ORDER = rlsarx_pkg::MODEL_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // plant_input, plant_output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // coefficient_index, coefficient_value, zero pad
  output logic        out_tlast,  // last_coefficient
  input  logic        cfg_wr_en,
  input  logic [rlsarx_pkg::IC_W-1:0] cfg_wr_data
);

  localparam int unsigned NC = 2 * MODEL_ORDER;
  localparam int unsigned IW = (NC > 1) ? $clog2(NC) : 1;
  localparam int unsigned DEPTH = NC * NC;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] ILAST = IW'(NC - 1);
  localparam logic [AW-1:0] NC_A = AW'(NC);

  typedef enum logic [7:0] {
    ST_INIT = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_RD   = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_WAIT = 8'b0001_0000,
    ST_ACC  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    PH_V, PH_W, PH_S, PH_E, PH_VW, PH_G, PH_PG, PH_TH
  } phase_t;

  typedef logic signed [rlsarx_pkg::SMP_W-1:0] smp_t;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [rlsarx_pkg::IC_W-1:0] ic_r, ic_nxt;
  smp_t reg_r [NC];
  smp_t reg_nxt [NC];
  rlsarx_pkg::q_t th_r [NC];
  rlsarx_pkg::q_t th_nxt [NC];
  rlsarx_pkg::q_t v_r [NC];
  rlsarx_pkg::q_t v_nxt [NC];
  rlsarx_pkg::q_t w_r [NC];
  rlsarx_pkg::q_t w_nxt [NC];
  smp_t y_r, y_nxt;
  rlsarx_pkg::q_t acc_r, acc_nxt, s_r, s_nxt, innov_r, innov_nxt;
  rlsarx_pkg::q_t g_r, g_nxt, t_r, t_nxt, pg_r, pg_nxt;

  rlsarx_pkg::q_t cov_mem [DEPTH];
  rlsarx_pkg::q_t mem_q;
  logic [AW-1:0] addr_ij, addr_ji;
  logic mem_we;
  rlsarx_pkg::q_t mem_wd;

  rlsarx_pkg::q_t op_a, op_b, mul_res, acc_sum, den, div_q;
  logic mul_done, div_start, div_done;

  assign addr_ij = AW'(i_r) * NC_A + AW'(j_r);
  assign addr_ji = AW'(j_r) * NC_A + AW'(i_r);
  assign acc_sum = rlsarx_pkg::sadd(acc_r, mul_res);

  // Covariance store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cov_mem[addr_ij] <= mem_wd;
    end
    if (state_r == ST_RD) begin
      mem_q <= cov_mem[(ph_r == PH_W) ? addr_ji : addr_ij];
    end
  end

  // Route operands to the shared multiplier
  always_comb begin
    unique case (ph_r)
      PH_V, PH_W, PH_PG: begin op_a = mem_q; op_b = rlsarx_pkg::smp2q(reg_r[j_r]); end
      PH_S:  begin op_a = rlsarx_pkg::smp2q(reg_r[i_r]); op_b = v_r[i_r]; end
      PH_E:  begin op_a = rlsarx_pkg::smp2q(reg_r[i_r]); op_b = th_r[i_r]; end
      PH_VW: begin op_a = v_r[i_r]; op_b = w_r[j_r]; end
      PH_G:  begin op_a = g_r; op_b = t_r; end
      default: begin op_a = innov_r; op_b = pg_r; end
    endcase
  end

  // Gain denominator, floored at one
  always_comb begin
    den = rlsarx_pkg::sadd(rlsarx_pkg::Q_ONE, s_r);
    if (den < rlsarx_pkg::Q_ONE) begin
      den = rlsarx_pkg::Q_ONE;
    end
  end

  rlsarx_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_MUL),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  rlsarx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .den   (den),
    .done  (div_done),
    .quo   (div_q)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ph_nxt = ph_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    ic_nxt = ic_r;
    reg_nxt = reg_r;
    th_nxt = th_r;
    v_nxt = v_r;
    w_nxt = w_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    s_nxt = s_r;
    innov_nxt = innov_r;
    g_nxt = g_r;
    t_nxt = t_r;
    pg_nxt = pg_r;
    mem_we = 1'b0;
    mem_wd = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        // load the diagonal, zero the off-diagonal, clear history
        for (int n = 0; n < NC; n++) begin
          reg_nxt[n] = '0;
          th_nxt[n] = '0;
        end
        mem_we = 1'b1;
        mem_wd = (i_r == j_r) ? rlsarx_pkg::q_t'({ic_r, {rlsarx_pkg::FRAC_W{1'b0}}}) : '0;
        if (j_r == ILAST) begin
          j_nxt = '0;
          if (i_r == ILAST) begin
            i_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          for (int n = 1; n < MODEL_ORDER; n++) begin
            reg_nxt[n] = reg_r[n-1];
          end
          reg_nxt[0] = in_tdata[15:0];
          y_nxt = in_tdata[31:16];
          ph_nxt = PH_V;
          i_nxt = '0;
          j_nxt = '0;
          acc_nxt = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = ST_RD;
        unique case (ph_r)
          PH_V, PH_W: begin
            acc_nxt = acc_sum;
            if (j_r == ILAST) begin
              if (ph_r == PH_V) v_nxt[i_r] = acc_sum;
              else w_nxt[i_r] = acc_sum;
              acc_nxt = '0;
              j_nxt = '0;
              if (i_r == ILAST) begin
                i_nxt = '0;
                ph_nxt = (ph_r == PH_V) ? PH_W : PH_S;
              end else begin
                i_nxt = i_r + IW'(1);
              end
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
          PH_S: begin
            acc_nxt = acc_sum;
            if (i_r == ILAST) begin
              s_nxt = acc_sum;
              acc_nxt = '0;
              i_nxt = '0;
              ph_nxt = PH_E;
            end else begin
              i_nxt = i_r + IW'(1);
            end
          end
          PH_E: begin
            acc_nxt = acc_sum;
            if (i_r == ILAST) begin
              innov_nxt = rlsarx_pkg::ssub(rlsarx_pkg::smp2q(y_r), acc_sum);
              acc_nxt = '0;
              i_nxt = '0;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end else begin
              i_nxt = i_r + IW'(1);
            end
          end
          PH_VW: begin
            // keep the v*w product for the gain product
            t_nxt = mul_res;
            ph_nxt = PH_G;
            state_nxt = ST_MUL;
          end
          PH_G: begin
            mem_we = 1'b1;
            mem_wd = rlsarx_pkg::ssub(mem_q, mul_res);
            ph_nxt = PH_VW;
            if (j_r == ILAST) begin
              j_nxt = '0;
              if (i_r == ILAST) begin
                i_nxt = '0;
                ph_nxt = PH_PG;
              end else begin
                i_nxt = i_r + IW'(1);
              end
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
          PH_PG: begin
            acc_nxt = acc_sum;
            if (j_r == ILAST) begin
              pg_nxt = acc_sum;
              acc_nxt = '0;
              j_nxt = '0;
              ph_nxt = PH_TH;
              state_nxt = ST_MUL;
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
          default: begin
            th_nxt[i_r] = rlsarx_pkg::sadd(th_r[i_r], mul_res);
            ph_nxt = PH_PG;
            if (i_r == ILAST) begin
              // shift the response into the output half
              for (int n = MODEL_ORDER + 1; n < NC; n++) begin
                reg_nxt[n] = reg_r[n-1];
              end
              reg_nxt[MODEL_ORDER] = y_r;
              i_nxt = '0;
              k_nxt = '0;
              state_nxt = ST_OUT;
            end else begin
              i_nxt = i_r + IW'(1);
            end
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          g_nxt = div_q;
          ph_nxt = PH_VW;
          i_nxt = '0;
          j_nxt = '0;
          state_nxt = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          if (k_r == ILAST) begin
            k_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + IW'(1);
          end
        end
      end
      default: state_nxt = ST_INIT;
    endcase
    // restart identification on a register write
    if (cfg_wr_en) begin
      ic_nxt = cfg_wr_data;
      i_nxt = '0;
      j_nxt = '0;
      state_nxt = ST_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      ph_r <= PH_V;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      ic_r <= rlsarx_pkg::IC_RESET;
    end else begin
      state_r <= state_nxt;
      ph_r <= ph_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      ic_r <= ic_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reg_r <= reg_nxt;
    th_r <= th_nxt;
    v_r <= v_nxt;
    w_r <= w_nxt;
    y_r <= y_nxt;
    acc_r <= acc_nxt;
    s_r <= s_nxt;
    innov_r <= innov_nxt;
    g_r <= g_nxt;
    t_r <= t_nxt;
    pg_r <= pg_nxt;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast = (k_r == ILAST);
  assign out_tdata = {4'b0, th_r[k_r], rlsarx_pkg::IDX_W'(k_r)};

  // Input and output never open together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while results pending");

  // Last result returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !cfg_wr_en) |=> in_tready)
    else $error("not idle after last result");

  // Multiplier completes only while awaited
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_WAIT || $past(cfg_wr_en)))
    else $error("unexpected multiplier completion");

endmodule

FILE: tb/rls_arx_identifier_tb.sv
module rls_arx_identifier_tb;

  localparam int NC = 2 * rlsarx_pkg::MODEL_ORDER_DEF;
  localparam int NO = rlsarx_pkg::MODEL_ORDER_DEF;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [3:0]     idx;
    rlsarx_pkg::q_t val;
    logic           last;
  } coef_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [rlsarx_pkg::IC_W-1:0] cfg_wr_data = '0;

  // Identifier state mirror
  logic signed [15:0] phi_smp [NC];
  rlsarx_pkg::q_t cov [NC][NC];
  rlsarx_pkg::q_t theta [NC];
  logic [rlsarx_pkg::IC_W-1:0] cov_init;

  coef_t coef_q[$];
  int err_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cyc = 0;

  rls_arx_identifier DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Q24 product, truncated toward zero, saturated
  function automatic rlsarx_pkg::q_t qmul(rlsarx_pkg::q_t a, rlsarx_pkg::q_t b);
    logic signed [96:0] p;
    logic signed [96:0] t;
    p = 97'(a) * 97'(b);
    if (p < 0) t = -((-p) >>> rlsarx_pkg::FRAC_W);
    else t = p >>> rlsarx_pkg::FRAC_W;
    if (t > 97'(rlsarx_pkg::Q_MAX)) return rlsarx_pkg::Q_MAX;
    if (t < 97'(rlsarx_pkg::Q_MIN)) return rlsarx_pkg::Q_MIN;
    return rlsarx_pkg::q_t'(t);
  endfunction

  function automatic void restart_identification();
    for (int i = 0; i < NC; i++) begin
      phi_smp[i] = '0;
      theta[i] = '0;
      for (int j = 0; j < NC; j++)
        cov[i][j] = (i == j) ?
          rlsarx_pkg::q_t'({25'd0, cov_init} << rlsarx_pkg::FRAC_W) : '0;
    end
  endfunction

  // One RLS step; push the updated estimates
  function automatic void rls_update(logic signed [15:0] u, logic signed [15:0] y);
    rlsarx_pkg::q_t phi [NC];
    rlsarx_pkg::q_t v [NC];
    rlsarx_pkg::q_t w [NC];
    rlsarx_pkg::q_t pg [NC];
    rlsarx_pkg::q_t s, den, g, innov, a, b;
    logic [96:0] quo;
    coef_t c;
    for (int i = NO - 1; i > 0; i--) phi_smp[i] = phi_smp[i-1];
    phi_smp[0] = u;
    for (int i = 0; i < NC; i++) phi[i] = rlsarx_pkg::smp2q(phi_smp[i]);
    for (int i = 0; i < NC; i++) begin
      a = '0; b = '0;
      for (int j = 0; j < NC; j++) begin
        a = rlsarx_pkg::sadd(a, qmul(cov[i][j], phi[j]));
        b = rlsarx_pkg::sadd(b, qmul(phi[j], cov[j][i]));
      end
      v[i] = a; w[i] = b;
    end
    s = '0; innov = '0;
    for (int i = 0; i < NC; i++) begin
      s = rlsarx_pkg::sadd(s, qmul(phi[i], v[i]));
      innov = rlsarx_pkg::sadd(innov, qmul(phi[i], theta[i]));
    end
    innov = rlsarx_pkg::ssub(rlsarx_pkg::smp2q(y), innov);
    den = rlsarx_pkg::sadd(rlsarx_pkg::Q_ONE, s);
    // clamp a denominator below one up to one
    if (den < rlsarx_pkg::Q_ONE) den = rlsarx_pkg::Q_ONE;
    quo = (97'd1 << 48) / 97'(den);
    g = rlsarx_pkg::q_t'(quo);
    for (int i = 0; i < NC; i++)
      for (int j = 0; j < NC; j++)
        cov[i][j] = rlsarx_pkg::ssub(cov[i][j], qmul(g, qmul(v[i], w[j])));
    for (int i = 0; i < NC; i++) begin
      a = '0;
      for (int j = 0; j < NC; j++) a = rlsarx_pkg::sadd(a, qmul(cov[i][j], phi[j]));
      pg[i] = a;
    end
    for (int i = 0; i < NC; i++) theta[i] = rlsarx_pkg::sadd(theta[i], qmul(innov, pg[i]));
    for (int i = NC - 1; i > NO; i--) phi_smp[i] = phi_smp[i-1];
    phi_smp[NO] = y;
    for (int i = 0; i < NC; i++) begin
      c.idx = 4'(i);
      c.val = theta[i];
      c.last = (i == NC - 1);
      coef_q.push_back(c);
    end
  endfunction

  // Receiver stall and result check
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (out_tvalid && out_tready) begin
      if (coef_q.size() == 0) begin
        $error("unexpected item idx=%0d", out_tdata[3:0]);
        err_cnt++;
      end else begin
        coef_t e;
        e = coef_q.pop_front();
        if (out_tdata[3:0] !== e.idx) begin
          $error("coefficient_index exp %0d got %0d", e.idx, out_tdata[3:0]);
          err_cnt++;
        end
        if (out_tdata[51:4] !== e.val) begin
          $error("coefficient_value exp %0h got %0h", e.val, out_tdata[51:4]);
          err_cnt++;
        end
        if (out_tlast !== e.last) begin
          $error("last_coefficient exp %0b got %0b", e.last, out_tlast);
          err_cnt++;
        end
      end
    end
    if (cyc > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic signed [15:0] u, logic signed [15:0] y);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {y, u};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rls_update(u, y);
    @(negedge clk);
    in_tvalid <= 1'b0;
    // hold the drop before the next item
    @(negedge clk);
  endtask

  task automatic drain();
    while (coef_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_cov(logic [rlsarx_pkg::IC_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cov_init = v;
    restart_identification();
  endtask

  function automatic logic signed [15:0] rand_smp();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic test_directed();
    send_item(16'sh7FFF, 16'sh7FFF);
    send_item(16'sh8000, 16'sh8000);
    send_item(16'sh0000, 16'sh0000);
    send_item(16'sh0001, -16'sh0001);
    send_item(-16'sh0001, 16'sh0001);
    send_item(16'sh5555, 16'shAAAA);
    send_item(16'shAAAA, 16'sh5555);
    send_item(16'sh0000, 16'sh1234);
  endtask

  task automatic test_extreme_config();
    // zero covariance, then the extremes
    write_cov('0);
    send_item(16'sh0100, 16'sh0200);
    send_item(16'sh7FFF, 16'sh8000);
    write_cov(23'd1);
    send_item(16'sh0003, 16'sh0007);
    send_item(16'sh8000, 16'sh7FFF);
    send_item(16'sh0005, -16'sh0009);
    write_cov(23'h7FFFFF);
    send_item(16'sh7FFF, 16'sh7FFF);
    send_item(16'sh0001, 16'sh8000);
    send_item(16'shFFFF, 16'sh0002);
  endtask

  task automatic test_random(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int k = 0; k < n; k++) begin
      send_item(rand_smp(), rand_smp());
      // wait for all results once mid-phase
      if (k == n / 2) drain();
    end
  endtask

  initial begin
    cov_init = rlsarx_pkg::IC_RESET;
    restart_identification();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_extreme_config();
    write_cov(rlsarx_pkg::IC_RESET);
    test_random(80, 0, 0);
    write_cov(23'd100);
    test_random(70, 82, 0);
    write_cov(23'($urandom_range(1, 8388607)));
    test_random(70, 0, 82);
    write_cov(23'd1000);
    test_random(70, 37, 37);
    drain();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
